FILE: rtl/crc16_frame_rx_parser_macros.svh
// Assertion macros for the CRC-16 frame receive parser.
`ifndef CRC16_FRAME_RX_PARSER_MACROS_SVH
`define CRC16_FRAME_RX_PARSER_MACROS_SVH
`ifndef SYNTH
`define CRCFP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define CRCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRCFP_ASSERT(lbl, expr, msg)
`define CRCFP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/crcfp_pkg.sv
// Shared types, constants and the CRC byte update for the frame receive parser.
package crcfp_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register indexes on the configuration port
    localparam logic [1:0] REG_START_BYTE = 2'd0;
    localparam logic [1:0] REG_MAX_LEN    = 2'd1;
    localparam logic [1:0] REG_FIRST_CMD  = 2'd2;
    localparam logic [1:0] REG_LAST_CMD   = 2'd3;

    localparam logic [7:0] START_BYTE_RST = 8'd0;
    localparam logic [7:0] MAX_LEN_RST    = 8'd40;
    localparam logic [7:0] FIRST_CMD_RST  = 8'd2;
    localparam logic [7:0] LAST_CMD_RST   = 8'd9;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_LO   = 2'd1,
        ST_CRC_HI   = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_REPORT  = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] max_len;
        logic [7:0] first_cmd;
        logic [7:0] last_cmd;
    } t_cfg;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        t_status    status;
        logic [7:0] frame_cmd;
        logic [7:0] frame_len;
        logic       cmd_accepted;
        logic       sequence_wrapped;
        logic [7:0] next_expected;
    } t_result;

    // reflected CRC-16, one byte in eight bit steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/crcfp_cfg.sv
// Configuration register file for the frame receive parser.
module crcfp_cfg
    import crcfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= START_BYTE_RST;
            r_cfg.max_len    <= MAX_LEN_RST;
            r_cfg.first_cmd  <= FIRST_CMD_RST;
            r_cfg.last_cmd   <= LAST_CMD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_BYTE: r_cfg.start_byte <= i_cfg_data;
                REG_MAX_LEN:    r_cfg.max_len    <= i_cfg_data;
                REG_FIRST_CMD:  r_cfg.first_cmd  <= i_cfg_data;
                REG_LAST_CMD:   r_cfg.last_cmd   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/crcfp_core.sv
// Frame parse state machine with CRC check and poll command sequencing.
module crcfp_core
    import crcfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CRC_H = 3'd4
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [15:0] r_crc,      n_crc;
    logic [7:0]  r_held_cmd, n_held_cmd;
    logic [7:0]  r_held_len, n_held_len;
    logic [7:0]  r_left,     n_left;
    logic [7:0]  r_expected, n_expected;

    logic [15:0] c_crc_in;
    logic [15:0] c_crc_next;
    logic [8:0]  c_cmd_inc;
    logic        c_hit;
    t_kind       c_kind;
    t_status     c_status;
    logic [7:0]  c_pbyte;
    logic [7:0]  c_pidx;
    logic        c_acc;
    logic        c_wrap;

    assign c_crc_in   = (r_phase == PH_HUNT) ? CRC_INIT : r_crc;
    assign c_crc_next = crc_byte(c_crc_in, i_byte);
    assign c_cmd_inc  = {1'b0, r_expected} + 9'd1;

    always_comb begin
        n_phase    = r_phase;
        n_crc      = r_crc;
        n_held_cmd = r_held_cmd;
        n_held_len = r_held_len;
        n_left     = r_left;
        n_expected = r_expected;
        c_hit      = 1'b0;
        c_kind     = KIND_REPORT;
        c_status   = ST_GOOD;
        c_pbyte    = 8'd0;
        c_pidx     = 8'd0;
        c_acc      = 1'b0;
        c_wrap     = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.start_byte) begin
                    n_crc   = c_crc_next;
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_held_cmd = i_byte;
                n_crc      = c_crc_next;
                n_phase    = PH_LEN;
            end
            PH_LEN: begin
                n_held_len = i_byte;
                if (i_byte <= i_cfg.max_len) begin
                    n_left  = i_byte;
                    n_crc   = c_crc_next;
                    n_phase = PH_DATA;
                end else begin
                    n_phase  = PH_HUNT;
                    c_hit    = 1'b1;
                    c_status = ST_TOO_LONG;
                end
            end
            PH_DATA: begin
                if (r_left != 8'd0) begin
                    n_left  = r_left - 8'd1;
                    n_crc   = c_crc_next;
                    c_hit   = 1'b1;
                    c_kind  = KIND_PAYLOAD;
                    c_pbyte = i_byte;
                    c_pidx  = r_held_len - r_left;
                end else if (r_crc[7:0] == i_byte) begin
                    n_phase = PH_CRC_H;
                end else begin
                    n_phase  = PH_HUNT;
                    c_hit    = 1'b1;
                    c_status = ST_CRC_LO;
                end
            end
            PH_CRC_H: begin
                n_phase = PH_HUNT;
                c_hit   = 1'b1;
                if (r_crc[15:8] != i_byte) begin
                    c_status = ST_CRC_HI;
                end else if (r_held_cmd == r_expected) begin
                    // advance at nine bits so 255 wraps instead of rolling to 0
                    c_acc = 1'b1;
                    if (c_cmd_inc > {1'b0, i_cfg.last_cmd}) begin
                        n_expected = i_cfg.first_cmd;
                        c_wrap     = 1'b1;
                    end else begin
                        n_expected = c_cmd_inc[7:0];
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_crc      <= CRC_INIT;
            r_held_cmd <= 8'd0;
            r_held_len <= 8'd0;
            r_left     <= 8'd0;
            r_expected <= FIRST_CMD_RST;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_crc      <= n_crc;
            r_held_cmd <= n_held_cmd;
            r_held_len <= n_held_len;
            r_left     <= n_left;
            r_expected <= n_expected;
        end
    end

    assign o_res_valid            = i_fire && c_hit;
    assign o_res.kind             = c_kind;
    assign o_res.payload_byte     = c_pbyte;
    assign o_res.payload_index    = c_pidx;
    assign o_res.status           = c_status;
    assign o_res.frame_cmd        = n_held_cmd;
    assign o_res.frame_len        = n_held_len;
    assign o_res.cmd_accepted     = c_acc;
    assign o_res.sequence_wrapped = c_wrap;
    assign o_res.next_expected    = n_expected;

endmodule

FILE: rtl/crc16_frame_rx_parser.sv
// Top level of the CRC-16 frame receive parser: input register, core, result register.
//
// Channel   Direction  Width  Contents
// s_axis    in         8      tdata: rx_byte
// m_axis    out        48+1   tdata: payload_byte, payload_index, status, frame_cmd,
//                             frame_len, cmd_accepted, sequence_wrapped, next_expected;
//                             tuser: kind
// i_cfg     in         2+8    register index, write data
//
// One item per cycle unless m_axis_tready stalls the result; an accepted item waits in
// the input register, then the parse logic loads its result into the result register.
// The CRC update is eight fixed bit steps on the registered byte, done combinationally.
// Reset is synchronous: it empties both registers, returns to start hunting and
// restores the register defaults.
// While a result waits and m_axis_tready is low, the result holds and at most one more
// item is taken into the input register.
module crc16_frame_rx_parser
    import crcfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] payload_byte, [15:8] payload_index, [17:16] status, [25:18] frame_cmd,
    // [33:26] frame_len, [34] cmd_accepted, [35] sequence_wrapped,
    // [43:36] next_expected, [47:44] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] kind
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

`include "crc16_frame_rx_parser_macros.svh"

    t_cfg       c_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       c_adv;
    logic       c_fire;
    logic       c_res_valid;
    t_result    c_res;
    logic       c_out_pay;
    logic       c_out_wrap;
    logic       c_out_dirty;
    logic       c_idx_ok;

    crcfp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (c_cfg)
    );

    // advance the input register when the result slot is free or draining
    assign c_adv         = !r_out_valid || m_axis_tready;
    assign c_fire        = r_in_valid && c_adv;
    assign s_axis_tready = !r_in_valid || c_adv;

    crcfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (c_fire),
        .i_byte      (r_in_byte),
        .i_cfg       (c_cfg),
        .o_res_valid (c_res_valid),
        .o_res       (c_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (c_adv) begin
                r_out_valid <= c_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (c_adv && c_res_valid) begin
            r_out <= c_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {4'd0, r_out.next_expected, r_out.sequence_wrapped,
                            r_out.cmd_accepted, r_out.frame_len, r_out.frame_cmd,
                            r_out.status, r_out.payload_index, r_out.payload_byte};

    assign c_out_pay   = r_out_valid && r_out.kind == KIND_PAYLOAD;
    assign c_out_wrap  = r_out_valid && r_out.sequence_wrapped;
    assign c_out_dirty = r_out.status != ST_GOOD || r_out.cmd_accepted || r_out.sequence_wrapped;
    assign c_idx_ok    = r_out.payload_index < r_out.frame_len;

    `CRCFP_ASSERT(a_payload_clean, !(c_out_pay && c_out_dirty), "payload carries report fields")
    `CRCFP_ASSERT(a_wrap_needs_accept, !c_out_wrap || r_out.cmd_accepted, "wrap without accept")
    `CRCFP_ASSERT(a_index_in_frame, !c_out_pay || c_idx_ok, "payload index past length")
    `CRCFP_ASSERT_NEXT(a_stall_only_full, !s_axis_tready, r_in_valid, "stall while empty")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the CRC-16 frame receive parser.
`timescale 1ns / 100ps

module tb_top;
    import crcfp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 20;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_CMD    = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_CRC_HI = 3'd4;

    localparam int FLAW_NONE   = 0;
    localparam int FLAW_CRC_LO = 1;
    localparam int FLAW_CRC_HI = 2;
    localparam int FLAW_CUT    = 3;

    typedef struct {
        bit         is_write;
        logic [1:0] idx;
        logic [7:0] value;
        bit         tail;
    } t_plan_op;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_idx     = REG_START_BYTE;
    logic [7:0]  i_cfg_data    = 8'h00;

    t_plan_op rx_plan[$];
    t_result  frame_results_due[$];
    int       mismatches  = 0;
    int       idle_cycles = 0;
    bit       tail_phase  = 1'b0;

    // parser mirror: registers and frame state
    logic [7:0]  pr_start, pr_max, pr_first, pr_last;
    logic [2:0]  pr_phase;
    logic [15:0] pr_crc;
    logic [7:0]  pr_cmd, pr_len, pr_left, pr_exp;

    // planner's own view of the registers and the poll sequence
    logic [7:0]  pl_start, pl_max, pl_first, pl_last, pl_exp;
    bit          pl_tail;

    always #5 i_clk = ~i_clk;

    crc16_frame_rx_parser uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        for (int n = 0; n < 8; n++) begin
            r = {1'b0, r[15:1]} ^ (r[0] ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic reset_parser_mirror();
        pr_start = START_BYTE_RST;
        pr_max   = MAX_LEN_RST;
        pr_first = FIRST_CMD_RST;
        pr_last  = LAST_CMD_RST;
        pr_phase = PH_HUNT;
        pr_crc   = CRC_INIT;
        pr_cmd   = 8'h00;
        pr_len   = 8'h00;
        pr_left  = 8'h00;
        pr_exp   = FIRST_CMD_RST;
    endtask

    task automatic write_mirror_reg(input logic [1:0] idx, input logic [7:0] v);
        case (idx)
            REG_START_BYTE: pr_start = v;
            REG_MAX_LEN:    pr_max   = v;
            REG_FIRST_CMD:  pr_first = v;
            REG_LAST_CMD:   pr_last  = v;
            default: ;
        endcase
    endtask

    // advance the mirror by one received byte and queue the result it causes
    task automatic parse_byte(input logic [7:0] b);
        t_result    r;
        bit         has_result;
        logic [8:0] bumped;
        r = '0;
        has_result = 1'b0;
        case (pr_phase)
            PH_HUNT: begin
                if (b == pr_start) begin
                    pr_crc   = crc16_step(CRC_INIT, b);
                    pr_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                pr_cmd   = b;
                pr_crc   = crc16_step(pr_crc, b);
                pr_phase = PH_LEN;
            end
            PH_LEN: begin
                pr_len = b;
                if (b <= pr_max) begin
                    pr_left  = b;
                    pr_crc   = crc16_step(pr_crc, b);
                    pr_phase = PH_BODY;
                end else begin
                    pr_phase   = PH_HUNT;
                    has_result = 1'b1;
                    r.kind     = KIND_REPORT;
                    r.status   = ST_TOO_LONG;
                end
            end
            PH_BODY: begin
                if (pr_left != 8'd0) begin
                    r.kind          = KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = pr_len - pr_left;
                    pr_left         = pr_left - 8'd1;
                    pr_crc          = crc16_step(pr_crc, b);
                    has_result      = 1'b1;
                end else if (pr_crc[7:0] == b) begin
                    pr_phase = PH_CRC_HI;
                end else begin
                    pr_phase   = PH_HUNT;
                    has_result = 1'b1;
                    r.kind     = KIND_REPORT;
                    r.status   = ST_CRC_LO;
                end
            end
            PH_CRC_HI: begin
                pr_phase   = PH_HUNT;
                has_result = 1'b1;
                r.kind     = KIND_REPORT;
                if (pr_crc[15:8] != b) begin
                    r.status = ST_CRC_HI;
                end else begin
                    r.status = ST_GOOD;
                    if (pr_cmd == pr_exp) begin
                        r.cmd_accepted = 1'b1;
                        // 9-bit sum, so 255 wraps to the first command instead of 0
                        bumped = {1'b0, pr_exp} + 9'd1;
                        if (bumped > {1'b0, pr_last}) begin
                            pr_exp             = pr_first;
                            r.sequence_wrapped = 1'b1;
                        end else begin
                            pr_exp = bumped[7:0];
                        end
                    end
                end
            end
            default: pr_phase = PH_HUNT;
        endcase
        if (has_result) begin
            r.frame_cmd     = pr_cmd;
            r.frame_len     = pr_len;
            r.next_expected = pr_exp;
            frame_results_due.push_back(r);
        end
    endtask

    task automatic plan_byte(input logic [7:0] b);
        t_plan_op op;
        op.is_write = 1'b0;
        op.idx      = REG_START_BYTE;
        op.value    = b;
        op.tail     = pl_tail;
        rx_plan.push_back(op);
    endtask

    task automatic plan_write(input logic [1:0] idx, input logic [7:0] v);
        t_plan_op op;
        op.is_write = 1'b1;
        op.idx      = idx;
        op.value    = v;
        op.tail     = pl_tail;
        rx_plan.push_back(op);
        case (idx)
            REG_START_BYTE: pl_start = v;
            REG_MAX_LEN:    pl_max   = v;
            REG_FIRST_CMD:  pl_first = v;
            REG_LAST_CMD:   pl_last  = v;
            default: ;
        endcase
    endtask

    task automatic plan_frame(input logic [7:0] cmd, input logic [7:0] len, input int flaw);
        logic [15:0] c;
        logic [7:0]  d;
        c = crc16_step(CRC_INIT, pl_start);
        plan_byte(pl_start);
        c = crc16_step(c, cmd);
        plan_byte(cmd);
        plan_byte(len);
        if (len > pl_max) begin
            return;
        end
        c = crc16_step(c, len);
        for (int k = 0; k < int'(len); k++) begin
            d = 8'($urandom);
            c = crc16_step(c, d);
            plan_byte(d);
        end
        if (flaw == FLAW_CUT) begin
            return;
        end
        plan_byte(c[7:0] ^ ((flaw == FLAW_CRC_LO) ? 8'($urandom_range(1, 255)) : 8'h00));
        if (flaw == FLAW_CRC_LO) begin
            return;
        end
        plan_byte(c[15:8] ^ ((flaw == FLAW_CRC_HI) ? 8'($urandom_range(1, 255)) : 8'h00));
        if (flaw == FLAW_NONE && cmd == pl_exp) begin
            pl_exp = ({1'b0, pl_exp} + 9'd1 > {1'b0, pl_last}) ? pl_first : pl_exp + 8'd1;
        end
    endtask

    // mostly well-formed frames, the rest broken frames and line noise
    task automatic plan_random(input int n);
        int         goal;
        int         pick;
        int         cap;
        logic [7:0] cmd;
        logic [7:0] len;
        goal = rx_plan.size() + n;
        while (rx_plan.size() < goal) begin
            pick = $urandom_range(0, 99);
            cmd  = ($urandom_range(0, 1) == 1) ? pl_exp : 8'($urandom);
            cap  = (pl_max < 8'd6) ? int'(pl_max) : 6;
            len  = 8'($urandom_range(0, cap));
            if ($urandom_range(0, 59) == 0) begin
                len = pl_max;
            end
            if (pick < 60) begin
                plan_frame(cmd, len, FLAW_NONE);
            end else if (pick < 70) begin
                plan_frame(cmd, len, FLAW_CRC_LO);
            end else if (pick < 80) begin
                plan_frame(cmd, len, FLAW_CRC_HI);
            end else if (pick < 88) begin
                if (pl_max != 8'hFF) begin
                    plan_frame(cmd, 8'($urandom_range(int'(pl_max) + 1, 255)), FLAW_NONE);
                end else begin
                    plan_byte(8'($urandom));
                end
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 3)) plan_byte(8'($urandom));
            end else begin
                plan_frame(cmd, len, FLAW_CUT);
            end
        end
    endtask

    // rx side: present planned items, apply register writes once the parser is idle
    always @(posedge i_clk) begin : drive_rx
        t_plan_op   head;
        logic       nxt_valid;
        logic [7:0] nxt_data;
        logic       nxt_we;
        logic [1:0] nxt_idx;
        logic [7:0] nxt_cfg;
        int         gap_left;
        int         quiet_cycles;
        int         steady_left;
        if (!i_rst_n) begin
            reset_parser_mirror();
            gap_left      = 0;
            quiet_cycles  = 0;
            steady_left   = 0;
            s_axis_tvalid <= 1'b0;
            i_cfg_we      <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
            end
            nxt_valid = s_axis_tvalid && !s_axis_tready;
            nxt_data  = s_axis_tdata;
            nxt_we    = 1'b0;
            nxt_idx   = i_cfg_idx;
            nxt_cfg   = i_cfg_data;
            if (!s_axis_tvalid && !m_axis_tvalid && frame_results_due.size() == 0) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (steady_left > 0) begin
                steady_left--;
            end else if ($urandom_range(0, 60) == 0) begin
                steady_left = $urandom_range(20, 60);
            end
            if (!nxt_valid && rx_plan.size() != 0) begin
                head = rx_plan[0];
                if (head.is_write) begin
                    if (quiet_cycles >= SETTLE_CYCLES) begin
                        nxt_we  = 1'b1;
                        nxt_idx = head.idx;
                        nxt_cfg = head.value;
                        write_mirror_reg(head.idx, head.value);
                        void'(rx_plan.pop_front());
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else if (!head.tail && steady_left == 0 && $urandom_range(0, 4) == 0) begin
                    gap_left = $urandom_range(0, 7);
                end else begin
                    nxt_valid  = 1'b1;
                    nxt_data   = head.value;
                    tail_phase = head.tail;
                    void'(rx_plan.pop_front());
                end
            end
            s_axis_tvalid <= nxt_valid;
            s_axis_tdata  <= nxt_data;
            i_cfg_we      <= nxt_we;
            i_cfg_idx     <= nxt_idx;
            i_cfg_data    <= nxt_cfg;
        end
    end

    // result side: random backpressure, compare each result with the oldest one due
    always @(posedge i_clk) begin : watch_results
        t_result got;
        t_result want;
        logic    nxt_ready;
        int      stall_left;
        int      steady_left;
        if (!i_rst_n) begin
            stall_left    = 0;
            steady_left   = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind             = t_kind'(m_axis_tuser);
                got.payload_byte     = m_axis_tdata[7:0];
                got.payload_index    = m_axis_tdata[15:8];
                got.status           = t_status'(m_axis_tdata[17:16]);
                got.frame_cmd        = m_axis_tdata[25:18];
                got.frame_len        = m_axis_tdata[33:26];
                got.cmd_accepted     = m_axis_tdata[34];
                got.sequence_wrapped = m_axis_tdata[35];
                got.next_expected    = m_axis_tdata[43:36];
                if (frame_results_due.size() == 0) begin
                    report_mismatch($sformatf("result with none due: tuser %0b tdata %h",
                                              m_axis_tuser, m_axis_tdata));
                end else begin
                    want = frame_results_due.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("kind got %0d want %0d",
                                                  got.kind, want.kind));
                    if (got.payload_byte !== want.payload_byte)
                        report_mismatch($sformatf("payload_byte got %h want %h",
                                                  got.payload_byte, want.payload_byte));
                    if (got.payload_index !== want.payload_index)
                        report_mismatch($sformatf("payload_index got %0d want %0d",
                                                  got.payload_index, want.payload_index));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got.status, want.status));
                    if (got.frame_cmd !== want.frame_cmd)
                        report_mismatch($sformatf("frame_cmd got %h want %h",
                                                  got.frame_cmd, want.frame_cmd));
                    if (got.frame_len !== want.frame_len)
                        report_mismatch($sformatf("frame_len got %0d want %0d",
                                                  got.frame_len, want.frame_len));
                    if (got.cmd_accepted !== want.cmd_accepted)
                        report_mismatch($sformatf("cmd_accepted got %0b want %0b",
                                                  got.cmd_accepted, want.cmd_accepted));
                    if (got.sequence_wrapped !== want.sequence_wrapped)
                        report_mismatch($sformatf("sequence_wrapped got %0b want %0b",
                                                  got.sequence_wrapped, want.sequence_wrapped));
                    if (got.next_expected !== want.next_expected)
                        report_mismatch($sformatf("next_expected got %h want %h",
                                                  got.next_expected, want.next_expected));
                end
            end
            if (steady_left > 0) begin
                steady_left--;
            end else if ($urandom_range(0, 60) == 0) begin
                steady_left = $urandom_range(20, 60);
            end
            if (tail_phase || steady_left > 0) begin
                nxt_ready = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 7);
                nxt_ready  = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_axis_tready <= nxt_ready;
        end
    end

    // end the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pl_start = START_BYTE_RST;
        pl_max   = MAX_LEN_RST;
        pl_first = FIRST_CMD_RST;
        pl_last  = LAST_CMD_RST;
        pl_exp   = FIRST_CMD_RST;
        pl_tail  = 1'b0;

        // directed: noise while hunting, good poll, too long, both CRC faults, unpolled command
        plan_byte(8'hFF);
        plan_frame(FIRST_CMD_RST, 8'd1, FLAW_NONE);
        plan_frame(8'hFF, MAX_LEN_RST + 8'd1, FLAW_NONE);
        plan_frame(8'd3, 8'd0, FLAW_CRC_LO);
        plan_frame(8'd3, 8'd0, FLAW_CRC_HI);
        plan_frame(8'h00, 8'd0, FLAW_NONE);
        plan_random(150);

        // last_cmd 0 forces a wrap to 254, then 255 wraps without rolling over
        plan_write(REG_START_BYTE, 8'hFF);
        plan_write(REG_MAX_LEN, 8'hFF);
        plan_write(REG_FIRST_CMD, 8'd254);
        plan_write(REG_LAST_CMD, 8'd0);
        plan_random(120);
        plan_write(REG_LAST_CMD, 8'hFF);
        plan_random(150);

        // only empty payloads pass
        plan_write(REG_START_BYTE, 8'($urandom));
        plan_write(REG_MAX_LEN, 8'h00);
        plan_write(REG_FIRST_CMD, 8'h00);
        plan_write(REG_LAST_CMD, 8'd3);
        plan_random(150);

        plan_write(REG_START_BYTE, 8'($urandom));
        plan_write(REG_MAX_LEN, 8'($urandom_range(4, 40)));
        plan_write(REG_FIRST_CMD, 8'($urandom_range(0, 200)));
        plan_write(REG_LAST_CMD, pl_first + 8'($urandom_range(0, 20)));
        plan_random(230);
        pl_tail = 1'b1;
        plan_random(150);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (rx_plan.size() != 0 || s_axis_tvalid || frame_results_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_results_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
